// File: rtl/core/ppps_pkg.sv
// Package with payload types, geometry constants and per-row lookup tables of the pixel shader.
package ppps_pkg;

    // Screen and texture geometry.
    localparam int SCREEN_WIDTH   = 320;
    localparam int SCREEN_HEIGHT  = 200;
    localparam int TEXTURE_PERIOD = 256;
    localparam int TILE_SIZE      = 64;
    localparam int EYE_HEIGHT     = 100;

    localparam int VIEW      = SCREEN_HEIGHT / 2;
    localparam int SKY_DEN   = (VIEW - 1) * (VIEW - 1);
    localparam int FOG_DEN   = VIEW * VIEW;
    localparam int HALF_W    = SCREEN_WIDTH / 2;
    localparam int U_SCALE   = EYE_HEIGHT * SCREEN_WIDTH * 256 / TEXTURE_PERIOD;
    localparam int TEX_BITS  = $clog2(TEXTURE_PERIOD);
    localparam int TILE_BITS = $clog2(TILE_SIZE);
    localparam int TILE_W    = TEX_BITS - TILE_BITS;

    // Datapath widths.
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int DEPTH_W = 24;
    localparam int RECIP_W = 32;
    localparam int PROD_W  = 30;
    localparam int FOG_W   = 5;
    localparam int ROWS    = 1 << Y_W;

    // Configuration register indexes.
    localparam logic [1:0] REG_COS_YAW  = 2'd0;
    localparam logic [1:0] REG_SIN_YAW  = 2'd1;
    localparam logic [1:0] REG_OFFSET_U = 2'd2;
    localparam logic [1:0] REG_OFFSET_V = 2'd3;

    typedef struct packed {
        logic [X_W-1:0] screen_x;
        logic [Y_W-1:0] screen_y;
    } pixel_t;

    typedef struct packed {
        logic [6:0] color_index;
        logic       drawn;
    } shade_t;

    // Quotient of two nonnegative integers by shift and subtract.
    function automatic longint udiv(longint a, longint b);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int i = 62; i >= 0; i--)
        begin
            r = (r << 1) | ((a >> i) & longint'(1));
            if (r >= b)
            begin
                r = r - b;
                q = q | (longint'(1) << i);
            end
        end
        return q;
    endfunction

    // Sky color for every row, zero below the sky.
    function automatic logic [ROWS-1:0][6:0] build_sky();
        logic [ROWS-1:0][6:0] lut;
        lut = '0;
        for (int i = 0; i < VIEW; i++) begin
            lut[i] = 7'(64 + (63 * i * i) / SKY_DEN);
        end
        return lut;
    endfunction

    // Floor depth V of every floor row, rounded toward minus infinity.
    function automatic logic [ROWS-1:0][DEPTH_W-1:0] build_depth();
        logic [ROWS-1:0][DEPTH_W-1:0] lut;
        longint mag;
        longint n;
        longint q;
        lut = '0;
        mag = longint'(EYE_HEIGHT) * SCREEN_HEIGHT * 256;
        for (int i = SCREEN_HEIGHT - VIEW + 1; i < SCREEN_HEIGHT && i < ROWS; i++) begin
            n = 2 * i - SCREEN_HEIGHT;
            // The depth is negative, so its floor is the negated ceiling of the magnitude.
            q = udiv(mag, n);
            if (q * n != mag)
            begin
                q = q + 1;
            end
            lut[i] = DEPTH_W'(-q);
        end
        return lut;
    endfunction

    // Rounded-up reciprocal 2^32 / n of the row divisor of every floor row.
    function automatic logic [ROWS-1:0][RECIP_W-1:0] build_recip();
        logic [ROWS-1:0][RECIP_W-1:0] lut;
        longint n;
        lut = '0;
        for (int i = SCREEN_HEIGHT - VIEW + 1; i < SCREEN_HEIGHT && i < ROWS; i++) begin
            n = 2 * i - SCREEN_HEIGHT;
            lut[i] = RECIP_W'(udiv((longint'(1) << 32) + n - 1, n));
        end
        return lut;
    endfunction

    // Fogged shade of the four base shades for every floor row.
    function automatic logic [ROWS-1:0][4*FOG_W-1:0] build_fog();
        logic [ROWS-1:0][4*FOG_W-1:0] lut;
        int fy;
        lut = '0;
        for (int i = SCREEN_HEIGHT - VIEW + 1; i < SCREEN_HEIGHT && i < ROWS; i++) begin
            fy = SCREEN_HEIGHT - i;
            for (int k = 0; k < 4; k++) begin
                lut[i][k*FOG_W +: FOG_W] = FOG_W'(((27 + k) * (FOG_DEN - fy * fy)) / FOG_DEN);
            end
        end
        return lut;
    endfunction

    localparam logic [ROWS-1:0][6:0]         SKY_LUT   = build_sky();
    localparam logic [ROWS-1:0][DEPTH_W-1:0] DEPTH_LUT = build_depth();
    localparam logic [ROWS-1:0][RECIP_W-1:0] RECIP_LUT = build_recip();
    localparam logic [ROWS-1:0][4*FOG_W-1:0] FOG_LUT   = build_fog();

endpackage

// File: rtl/core/perspective_plane_pixel_shader.sv
// Top level of the perspective plane pixel shader: a five-stage pixel pipeline.
//
// One pixel request enters per clock and its palette index leaves from the stage-five register;
// with a ready result side the sustained rate is one pixel per cycle. Per-row terms (sky
// color, floor depth, divisor reciprocal, fog shades) come from constant row tables in
// stage one, the column divide is a reciprocal multiply in stage two with its correction in
// stage three, the yaw rotation uses four 24x16 multipliers in stage four, and stage five
// adds the walk offsets, picks the checker texel and holds the result. When the result is
// not taken, the whole pipeline holds. Configuration writes are taken in every cycle and
// should be made while no pixel is in flight.
module perspective_plane_pixel_shader
    import ppps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    input  pixel_t      pixel,
    output logic        result_valid,
    input  logic        result_ready,
    output shade_t      result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef struct packed {
        logic                 is_floor;
        logic                 is_sky;
        logic [6:0]           sky_color;
        logic [4*FOG_W-1:0]   fog;
    } side_t;

    // Configuration registers.
    logic signed [15:0] cos_yaw_reg;
    logic signed [15:0] sin_yaw_reg;
    logic [15:0]        offset_u_reg;
    logic [15:0]        offset_v_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_yaw_reg  <= 16'sd16384;
            sin_yaw_reg  <= '0;
            offset_u_reg <= '0;
            offset_v_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COS_YAW:  cos_yaw_reg  <= cfg_data;
                REG_SIN_YAW:  sin_yaw_reg  <= cfg_data;
                REG_OFFSET_U: offset_u_reg <= cfg_data;
                REG_OFFSET_V: offset_v_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // The pipeline advances unless a finished result is waiting.
    logic advance;
    assign advance     = !result_valid || result_ready;
    assign pixel_ready = advance;

    // Stage one: row tables, pixel classification and column distance.
    logic                 v1_reg;
    side_t                side1_reg, side1_next;
    logic [DEPTH_W-1:0]   depth1_reg;
    logic [RECIP_W-1:0]   recip1_reg;
    logic [DEPTH_W-1:0]   mag1_reg, mag1_next;
    logic                 neg1_reg, neg1_next;
    logic [Y_W-1:0]       n1_reg, n1_next;

    always_comb
    begin
        logic [X_W-1:0] col_dist;
        logic           in_col;
        in_col = pixel.screen_x < X_W'(SCREEN_WIDTH);
        side1_next.is_sky    = in_col && (pixel.screen_y < Y_W'(VIEW));
        side1_next.is_floor  = in_col && (pixel.screen_y > Y_W'(SCREEN_HEIGHT - VIEW))
                               && ({1'b0, pixel.screen_y} < (Y_W+1)'(SCREEN_HEIGHT));
        side1_next.sky_color = SKY_LUT[pixel.screen_y];
        side1_next.fog       = FOG_LUT[pixel.screen_y];
        neg1_next = pixel.screen_x > X_W'(HALF_W);
        col_dist = neg1_next ? (pixel.screen_x - X_W'(HALF_W))
                             : (X_W'(HALF_W) - pixel.screen_x);
        mag1_next = DEPTH_W'(U_SCALE) * DEPTH_W'(col_dist);
        n1_next   = Y_W'({pixel.screen_y, 1'b0} - (Y_W+1)'(SCREEN_HEIGHT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side1_reg  <= side1_next;
            depth1_reg <= DEPTH_LUT[pixel.screen_y];
            recip1_reg <= RECIP_LUT[pixel.screen_y];
            mag1_reg   <= mag1_next;
            neg1_reg   <= neg1_next;
            n1_reg     <= n1_next;
        end
    end

    // Stage two: quotient estimate by reciprocal multiply.
    logic                 v2_reg;
    side_t                side2_reg;
    logic [DEPTH_W-1:0]   depth2_reg;
    logic [DEPTH_W-1:0]   quot2_reg;
    logic [DEPTH_W-1:0]   mag2_reg;
    logic                 neg2_reg;
    logic [Y_W-1:0]       n2_reg;
    logic [DEPTH_W+RECIP_W-1:0] quot_prod;

    assign quot_prod = (DEPTH_W+RECIP_W)'(mag1_reg) * (DEPTH_W+RECIP_W)'(recip1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side2_reg  <= side1_reg;
            depth2_reg <= depth1_reg;
            quot2_reg  <= quot_prod[DEPTH_W+RECIP_W-1:RECIP_W];
            mag2_reg   <= mag1_reg;
            neg2_reg   <= neg1_reg;
            n2_reg     <= n1_reg;
        end
    end

    // Stage three: remainder test and signed floor of the column term U.
    logic                       v3_reg;
    side_t                      side3_reg;
    logic signed [DEPTH_W-1:0]  depth3_reg;
    logic signed [DEPTH_W-1:0]  u3_reg, u3_next;
    logic [DEPTH_W+Y_W-1:0]     back_prod;

    assign back_prod = (DEPTH_W+Y_W)'(quot2_reg) * (DEPTH_W+Y_W)'(n2_reg);

    always_comb
    begin
        logic inexact;
        inexact = back_prod != (DEPTH_W+Y_W)'(mag2_reg);
        if (neg2_reg)
        begin
            u3_next = -$signed(quot2_reg + DEPTH_W'(inexact));
        end
        else
        begin
            u3_next = $signed(quot2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side3_reg  <= side2_reg;
            depth3_reg <= depth2_reg;
            u3_reg     <= u3_next;
        end
    end

    // Stage four: yaw rotation products, low bits kept for the texel wrap.
    logic                v4_reg;
    side_t               side4_reg;
    logic [PROD_W-1:0]   uc4_reg, vs4_reg, us4_reg, vc4_reg;
    logic signed [DEPTH_W+15:0] m_uc, m_vs, m_us, m_vc;

    assign m_uc = u3_reg * cos_yaw_reg;
    assign m_vs = depth3_reg * sin_yaw_reg;
    assign m_us = u3_reg * sin_yaw_reg;
    assign m_vc = depth3_reg * cos_yaw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side4_reg <= side3_reg;
            uc4_reg   <= m_uc[PROD_W-1:0];
            vs4_reg   <= m_vs[PROD_W-1:0];
            us4_reg   <= m_us[PROD_W-1:0];
            vc4_reg   <= m_vc[PROD_W-1:0];
        end
    end

    // Stage five: walk offsets, checker texel, fog and result select.
    logic   result_valid_reg;
    shade_t result_reg, result_next;

    always_comb
    begin
        logic [PROD_W-1:0] sum_u;
        logic [PROD_W-1:0] sum_v;
        logic [15:0]       ru;
        logic [15:0]       rv;
        logic [TILE_W-1:0] tx;
        logic [TILE_W-1:0] ty;
        logic [7:0]        mix;
        logic [1:0]        hue;
        logic [FOG_W-1:0]  shade;
        sum_u = uc4_reg - vs4_reg;
        sum_v = us4_reg + vc4_reg;
        ru    = sum_u[PROD_W-1:14] + offset_u_reg;
        rv    = sum_v[PROD_W-1:14] + offset_v_reg;
        tx    = ru[8+TEX_BITS-1:8+TILE_BITS];
        ty    = rv[8+TEX_BITS-1:8+TILE_BITS];
        mix   = 8'(13) * 8'(tx) + 8'(7) * 8'(ty);
        hue   = mix[1:0];
        shade = side4_reg.fog[hue*FOG_W +: FOG_W];
        if (side4_reg.is_floor)
        begin
            result_next.color_index = {1'b0, tx[0] ^ ty[0], shade};
            result_next.drawn       = 1'b1;
        end
        else if (side4_reg.is_sky)
        begin
            result_next.color_index = side4_reg.sky_color;
            result_next.drawn       = 1'b1;
        end
        else
        begin
            result_next.color_index = '0;
            result_next.drawn       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/core/ppps_checker.sv
// Port-level checker of the pixel shader and its bind to the top level.
module ppps_checker
    import ppps_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        pixel_ready,
    input logic        result_valid,
    input logic        result_ready,
    input shade_t      result
);

    // A waiting result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result request dropped while stalled");

    // A waiting result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

    // An undrawn pixel always carries palette index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.drawn |-> result.color_index == 7'd0)
        else $error("undrawn pixel with nonzero color");

    // With no result waiting, the pipeline must take a new pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> pixel_ready)
        else $error("pixel stalled with empty output");

endmodule

bind perspective_plane_pixel_shader ppps_checker u_ppps_checker (.*);

// File: test/tb.sv
// Testbench for the perspective plane pixel shader: directed table and random pixels.
`timescale 1ns / 100ps

module tb;
    import ppps_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        pixel_valid;
    logic        pixel_ready;
    pixel_t      pixel;
    logic        result_valid;
    logic        result_ready;
    shade_t      result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    perspective_plane_pixel_shader i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the yaw and walk registers.
    logic signed [15:0] cos_q;
    logic signed [15:0] sin_q;
    logic [15:0]        walk_u;
    logic [15:0]        walk_v;

    shade_t shade_queue[$];
    int     mismatches;
    int     send_idle_pct;
    int     recv_idle_pct;
    logic   hold_off;
    event   hold_go;

    typedef struct {
        logic [8:0] x;
        logic [7:0] y;
        logic       known;
        logic [6:0] color;
        logic       drawn;
    } pixel_row_t;

    // Floor division for a positive divisor.
    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Palette index of one screen pixel under the current registers.
    function automatic shade_t shade_pixel(logic [8:0] x, logic [7:0] y);
        shade_t s;
        longint sx;
        longint sy;
        longint n;
        longint fy;
        longint dv;
        longint du;
        longint ru;
        longint rv;
        longint tu;
        longint tv;
        longint tx;
        longint ty;
        longint texel;
        longint view;
        sx = x;
        sy = y;
        view = SCREEN_HEIGHT / 2;
        s = '0;
        if (sx < SCREEN_WIDTH && sy < SCREEN_HEIGHT) begin
            if (sy < view) begin
                s.color_index = 7'(64 + (63 * sy * sy) / ((view - 1) * (view - 1)));
                s.drawn = 1'b1;
            end else if (sy > SCREEN_HEIGHT - view) begin
                n = 2 * sy - SCREEN_HEIGHT;
                fy = SCREEN_HEIGHT - sy;
                dv = floor_div(-longint'(EYE_HEIGHT) * SCREEN_HEIGHT * 256, n);
                du = floor_div(-longint'(EYE_HEIGHT) * SCREEN_WIDTH * (2 * sx - SCREEN_WIDTH)
                               * 128, longint'(TEXTURE_PERIOD) * n);
                ru = floor_div(du * cos_q - dv * sin_q, 16384) + walk_u;
                rv = floor_div(du * sin_q + dv * cos_q, 16384) + walk_v;
                tu = floor_div(ru, 256) % TEXTURE_PERIOD;
                tv = floor_div(rv, 256) % TEXTURE_PERIOD;
                if (tu < 0) tu = tu + TEXTURE_PERIOD;
                if (tv < 0) tv = tv + TEXTURE_PERIOD;
                tx = tu / TILE_SIZE;
                ty = tv / TILE_SIZE;
                texel = (((tx ^ ty) & 1) != 0 ? 32 : 0) + 27 + ((tx * 13 + ty * 7) & 3);
                s.color_index = 7'((texel & 32)
                                   + ((texel & 31) * (view * view - fy * fy)) / (view * view));
                s.drawn = 1'b1;
            end
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Long receiver hold-off, counted here while the sender keeps offering pixels.
    initial
    begin
        hold_off = 1'b0;
        @(hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Result side: random stalls, the long hold-off, and the check.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_ready <= 1'b0;
        end else begin
            if (result_valid && result_ready) begin
                if (shade_queue.size() == 0) begin
                    report_mismatch("unexpected result", int'(result.color_index), 0);
                end else begin
                    if (result.color_index !== shade_queue[0].color_index)
                        report_mismatch("color_index", int'(result.color_index),
                                        int'(shade_queue[0].color_index));
                    if (result.drawn !== shade_queue[0].drawn)
                        report_mismatch("drawn", int'(result.drawn),
                                        int'(shade_queue[0].drawn));
                    void'(shade_queue.pop_front());
                end
            end
            if (hold_off) begin
                result_ready <= 1'b0;
            end else begin
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one pixel request and wait for it to be taken.
    task automatic send_pixel(logic [8:0] x, logic [7:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel.screen_x <= x;
        pixel.screen_y <= y;
        shade_queue.push_back(shade_pixel(x, y));
        @(posedge clk);
        while (!pixel_ready) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        case (idx)
            REG_COS_YAW:  cos_q  = data;
            REG_SIN_YAW:  sin_q  = data;
            REG_OFFSET_U: walk_u = data;
            default:      walk_v = data;
        endcase
    endtask

    // Let the pipeline empty before touching the registers.
    task automatic drain();
        pixel_valid <= 1'b0;
        while (shade_queue.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    // Random pixel, mostly on screen, sometimes anywhere in the field range.
    task automatic random_pixel();
        if ($urandom_range(9) == 0)
            send_pixel(9'($urandom), 8'($urandom));
        else
            send_pixel(9'($urandom_range(SCREEN_WIDTH - 1)),
                       8'($urandom_range(SCREEN_HEIGHT - 1)));
    endtask

    pixel_row_t directed[] = '{
        '{9'd0,   8'd0,   1'b1, 7'd64,  1'b1},
        '{9'd319, 8'd99,  1'b1, 7'd127, 1'b1},
        '{9'd0,   8'd100, 1'b1, 7'd0,   1'b0},
        '{9'd160, 8'd100, 1'b1, 7'd0,   1'b0},
        '{9'd320, 8'd10,  1'b1, 7'd0,   1'b0},
        '{9'd511, 8'd150, 1'b1, 7'd0,   1'b0},
        '{9'd10,  8'd200, 1'b1, 7'd0,   1'b0},
        '{9'd511, 8'd255, 1'b1, 7'd0,   1'b0},
        '{9'd0,   8'd101, 1'b0, 7'd0,   1'b0},
        '{9'd319, 8'd101, 1'b0, 7'd0,   1'b0},
        '{9'd160, 8'd101, 1'b0, 7'd0,   1'b0},
        '{9'd159, 8'd150, 1'b0, 7'd0,   1'b0},
        '{9'd0,   8'd199, 1'b0, 7'd0,   1'b0},
        '{9'd319, 8'd199, 1'b0, 7'd0,   1'b0},
        '{9'd200, 8'd120, 1'b0, 7'd0,   1'b0},
        '{9'd50,  8'd50,  1'b0, 7'd0,   1'b0},
        '{9'd256, 8'd128, 1'b0, 7'd0,   1'b0}
    };

    logic [15:0] trig_set[6][2] = '{
        '{16'h4000, 16'h0000}, '{16'hC000, 16'h4000}, '{16'h2D41, 16'hD2BF},
        '{16'h7FFF, 16'h8000}, '{16'hFFFF, 16'h0001}, '{16'h0000, 16'hC000}
    };

    initial
    begin
        shade_t want;
        mismatches = 0;
        send_idle_pct = 20;
        recv_idle_pct = 47;
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        pixel = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_COS_YAW;
        cfg_data = '0;
        cos_q = 16'sd16384;
        sin_q = 16'sd0;
        walk_u = '0;
        walk_v = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under the reset registers.
        foreach (directed[i]) begin
            if (directed[i].known) begin
                want = shade_pixel(directed[i].x, directed[i].y);
                if (want.color_index !== directed[i].color)
                    report_mismatch("table color_index", int'(want.color_index),
                                    int'(directed[i].color));
                if (want.drawn !== directed[i].drawn)
                    report_mismatch("table drawn", int'(want.drawn), int'(directed[i].drawn));
            end
            send_pixel(directed[i].x, directed[i].y);
        end

        // Random phases, each under new registers; phases 0 to 3 idle at random, later ones do not.
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            write_reg(REG_COS_YAW, trig_set[phase][0]);
            write_reg(REG_SIN_YAW, trig_set[phase][1]);
            write_reg(REG_OFFSET_U, phase == 3 ? 16'hFFFF : 16'($urandom));
            write_reg(REG_OFFSET_V, phase == 3 ? 16'hFFFF : (phase == 0 ? 16'h0 : 16'($urandom)));
            cfg_valid <= 1'b0;
            if (phase == 2) begin
                send_idle_pct = 47;
                recv_idle_pct = 20;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 1) begin
                -> hold_go;
            end
            for (int k = 0; k < 205; k++) begin
                random_pixel();
            end
        end

        drain();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
